>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gravity step checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/tbgs_pkg.sv
// ----------------------------------------------------------------------------
// Two-body gravity step package
// Widths, register indexes, command codes and the controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbgs_pkg;

  // Field and arithmetic widths.
  localparam int unsigned DataW     = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned AxisN     = 3;
  localparam int unsigned AxisW     = 2;
  localparam int unsigned MulW      = 33;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned SumW      = 68;
  localparam int unsigned RootW     = SumW / 2;
  localparam int unsigned SremW     = RootW + 3;
  localparam int unsigned DistW     = 33;
  localparam int unsigned DdW       = 2 * DistW;
  localparam int unsigned D3W       = 3 * DistW;
  localparam int unsigned DremW     = D3W + 1;
  localparam int unsigned QuotW     = 31;
  localparam int unsigned IterW     = 6;
  localparam int unsigned SqrtIters = RootW;
  localparam int unsigned DivIters  = QuotW;
  localparam int unsigned CfgIdxW   = 2;

  // Reset values of the configuration registers (Q16.16).
  localparam logic [DataW-1:0] MassRst = 32'd65536;
  localparam logic [DataW-1:0] GravRst = 32'd65536;
  localparam logic [DataW-1:0] DtRst   = 32'd655;

  // Input action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MASS_ONE = 2'd0,
    CFG_MASS_TWO = 2'd1,
    CFG_GRAV     = 2'd2,
    CFG_DT       = 2'd3
  } cfg_idx_e;

  // Multiplier operand selection.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_DD,
    MUL_D3LO,
    MUL_D3HI,
    MUL_GM,
    MUL_K,
    MUL_KAD,
    MUL_POS
  } mul_sel_e;

  // Datapath register update operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_DIFF,
    OP_SQ_ACC,
    OP_CHECK,
    OP_SQRT_STEP,
    OP_DD,
    OP_D3LO,
    OP_D3HI,
    OP_GM,
    OP_K,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_VEL,
    OP_POS
  } op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    mul_sel_e         mul_sel;
    op_e              op;
    logic [AxisW-1:0] axis;
    logic             body;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic s_zero;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/tbgs_ctrl.sv
// ----------------------------------------------------------------------------
// Two-body gravity step controller
// Sequences the datapath through separation, square root, cube, coefficients,
// per-axis divisions, velocity and position updates, and runs both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tbgs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             action_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire tbgs_pkg::status_t status_i,
  output tbgs_pkg::cmd_t        cmd_o
);
  import tbgs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SQ    = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_SQRT  = 11'b000_0000_1000,
    S_CUBE  = 11'b000_0001_0000,
    S_COEF  = 11'b000_0010_0000,
    S_DIV   = 11'b000_0100_0000,
    S_DSTEP = 11'b000_1000_0000,
    S_VEL   = 11'b001_0000_0000,
    S_POS   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic             phase_q, phase_d;
  logic [AxisW-1:0] axis_q, axis_d;
  logic             body_q, body_d;
  logic [IterW-1:0] iter_q, iter_d;

  // Next-state and command logic.
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    axis_d       = axis_q;
    body_d       = body_q;
    iter_d       = iter_q;
    cmd_o        = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.op     = OP_NONE;
    cmd_o.axis   = axis_q;
    cmd_o.body   = body_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_STEP) begin
            cmd_o.op = OP_CLEAR;
            state_d  = S_SQ;
            axis_d   = '0;
            phase_d  = 1'b0;
          end else begin
            cmd_o.op = OP_LOAD;
          end
        end
      end

      // Separation per axis and sum of squares.
      S_SQ: begin
        if (!phase_q) begin
          cmd_o.mul_sel = MUL_SQ;
          cmd_o.op      = OP_DIFF;
          phase_d       = 1'b1;
        end else begin
          cmd_o.op = OP_SQ_ACC;
          phase_d  = 1'b0;
          if (axis_q == AxisW'(AxisN - 1)) begin
            state_d = S_CHECK;
            axis_d  = '0;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end

      S_CHECK: begin
        cmd_o.op = OP_CHECK;
        axis_d   = '0;
        body_d   = 1'b0;
        phase_d  = 1'b0;
        iter_d   = '0;
        if (status_i.s_zero) begin
          state_d = S_POS;
        end else begin
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (iter_q == IterW'(SqrtIters - 1)) begin
          state_d = S_CUBE;
          axis_d  = '0;
          phase_d = 1'b0;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end

      // Distance squared, then cubed in two partial products.
      S_CUBE: begin
        unique case (axis_q)
          2'd0: begin
            cmd_o.mul_sel = phase_q ? MUL_NONE : MUL_DD;
            cmd_o.op      = phase_q ? OP_DD : OP_NONE;
          end
          2'd1: begin
            cmd_o.mul_sel = phase_q ? MUL_NONE : MUL_D3LO;
            cmd_o.op      = phase_q ? OP_D3LO : OP_NONE;
          end
          2'd2: begin
            cmd_o.mul_sel = phase_q ? MUL_NONE : MUL_D3HI;
            cmd_o.op      = phase_q ? OP_D3HI : OP_NONE;
          end
          default: begin
            cmd_o.mul_sel = MUL_NONE;
            cmd_o.op      = OP_NONE;
          end
        endcase
        phase_d = !phase_q;
        if (phase_q) begin
          if (axis_q == 2'd2) begin
            state_d = S_COEF;
            axis_d  = '0;
            body_d  = 1'b0;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end

      // Coefficient per body: G*m, then times dt.
      S_COEF: begin
        if (axis_q[0]) begin
          cmd_o.mul_sel = phase_q ? MUL_NONE : MUL_K;
          cmd_o.op      = phase_q ? OP_K : OP_NONE;
        end else begin
          cmd_o.mul_sel = phase_q ? MUL_NONE : MUL_GM;
          cmd_o.op      = phase_q ? OP_GM : OP_NONE;
        end
        phase_d = !phase_q;
        if (phase_q) begin
          if (axis_q[0]) begin
            axis_d = '0;
            if (body_q) begin
              state_d = S_DIV;
              body_d  = 1'b0;
            end else begin
              body_d = 1'b1;
            end
          end else begin
            axis_d = 2'd1;
          end
        end
      end

      S_DIV: begin
        if (!phase_q) begin
          cmd_o.mul_sel = MUL_KAD;
          phase_d       = 1'b1;
        end else begin
          cmd_o.op = OP_DIV_INIT;
          phase_d  = 1'b0;
          iter_d   = '0;
          state_d  = S_DSTEP;
        end
      end

      S_DSTEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (iter_q == IterW'(DivIters - 1)) begin
          state_d = S_VEL;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end

      S_VEL: begin
        cmd_o.op = OP_VEL;
        state_d  = S_DIV;
        if (!body_q) begin
          body_d = 1'b1;
        end else begin
          body_d = 1'b0;
          if (axis_q == AxisW'(AxisN - 1)) begin
            axis_d  = '0;
            state_d = S_POS;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end

      // Position update, one component per multiply.
      S_POS: begin
        if (!phase_q) begin
          cmd_o.mul_sel = MUL_POS;
          phase_d       = 1'b1;
        end else begin
          cmd_o.op = OP_POS;
          phase_d  = 1'b0;
          if (axis_q == AxisW'(AxisN - 1)) begin
            axis_d = '0;
            if (body_q) begin
              body_d  = 1'b0;
              state_d = S_OUT;
            end else begin
              body_d = 1'b1;
            end
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end

      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
      axis_q  <= '0;
      body_q  <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      axis_q  <= axis_d;
      body_q  <= body_d;
      iter_q  <= iter_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbgs_dpath.sv
// ----------------------------------------------------------------------------
// Two-body gravity step datapath
// Body state, configuration registers, one shared 33x33 multiplier, a
// two-bit-per-cycle square root and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tbgs_dpath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tbgs_pkg::cmd_t                   cmd_i,
  output tbgs_pkg::status_t                     status_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tbgs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [tbgs_pkg::DataW-1:0]       cfg_data_i,
  input  wire logic                             body_sel_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_pos_x_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_pos_y_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_pos_z_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_vel_x_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_vel_y_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_vel_z_i,
  output logic signed [tbgs_pkg::DataW-1:0]     first_x_o,
  output logic signed [tbgs_pkg::DataW-1:0]     first_y_o,
  output logic signed [tbgs_pkg::DataW-1:0]     first_z_o,
  output logic signed [tbgs_pkg::DataW-1:0]     second_x_o,
  output logic signed [tbgs_pkg::DataW-1:0]     second_y_o,
  output logic signed [tbgs_pkg::DataW-1:0]     second_z_o,
  output logic                                  coincident_o
);
  import tbgs_pkg::*;

  localparam logic [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

  // Configuration registers.
  logic [DataW-1:0] mass1_q, mass2_q, grav_q, dt_q;

  // Body state.
  logic [DataW-1:0] pos1_q [AxisN];
  logic [DataW-1:0] pos2_q [AxisN];
  logic [DataW-1:0] vel1_q [AxisN];
  logic [DataW-1:0] vel2_q [AxisN];

  // Working registers.
  logic [ProdW-1:0] prod_q;
  logic [DataW-1:0] ad_q [AxisN];
  logic [AxisN-1:0] neg_q;
  logic [SumW-1:0]  s_q;
  logic [SremW-1:0] srem_q;
  logic [RootW-1:0] root_q;
  logic [DdW-1:0]   dd_q;
  logic [D3W-1:0]   d3_q;
  logic [DataW-1:0] gm_q;
  logic [DataW-1:0] k_q [2];
  logic [DremW-1:0] drem_q;
  logic [QuotW-1:0] quot_q;
  logic             ovf_q;
  logic             coin_q;

  // Saturate a Q32.32 product shifted down to Q16.16 into 32 unsigned bits.
  function automatic logic [DataW-1:0] sat_shift(input logic [ProdW-1:0] p);
    logic [DataW-1:0] r;
    if (|p[ProdW-1:DataW+FracW]) begin
      r = '1;
    end else begin
      r = p[DataW+FracW-1:FracW];
    end
    return r;
  endfunction

  // Separation on the selected axis.
  logic [DataW-1:0] p1_sel, p2_sel;
  logic [DataW:0]   d_now, d_neg;
  logic [DataW-1:0] ad_now;
  logic             neg_now;

  assign p1_sel  = pos1_q[cmd_i.axis];
  assign p2_sel  = pos2_q[cmd_i.axis];
  assign d_now   = {p2_sel[DataW-1], p2_sel} - {p1_sel[DataW-1], p1_sel};
  assign d_neg   = -d_now;
  assign neg_now = d_now[DataW];
  assign ad_now  = neg_now ? d_neg[DataW-1:0] : d_now[DataW-1:0];

  // Selected body component for velocity and position updates.
  logic [DataW-1:0] v_sel, p_sel, v_neg, v_mag;
  assign v_sel = cmd_i.body ? vel2_q[cmd_i.axis] : vel1_q[cmd_i.axis];
  assign p_sel = cmd_i.body ? pos2_q[cmd_i.axis] : pos1_q[cmd_i.axis];
  assign v_neg = -v_sel;
  assign v_mag = v_sel[DataW-1] ? v_neg : v_sel;

  logic [DistW-1:0] sep_len;
  assign sep_len = root_q[DistW-1:0];

  // Shared multiplier operand selection.
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SQ: begin
        mul_a = {1'b0, ad_now};
        mul_b = {1'b0, ad_now};
      end
      MUL_DD: begin
        mul_a = sep_len;
        mul_b = sep_len;
      end
      MUL_D3LO: begin
        mul_a = dd_q[DistW-1:0];
        mul_b = sep_len;
      end
      MUL_D3HI: begin
        mul_a = dd_q[DdW-1:DistW];
        mul_b = sep_len;
      end
      MUL_GM: begin
        mul_a = {1'b0, grav_q};
        mul_b = {1'b0, (cmd_i.body ? mass1_q : mass2_q)};
      end
      MUL_K: begin
        mul_a = {1'b0, gm_q};
        mul_b = {1'b0, dt_q};
      end
      MUL_KAD: begin
        mul_a = {1'b0, k_q[cmd_i.body]};
        mul_b = {1'b0, ad_q[cmd_i.axis]};
      end
      MUL_POS: begin
        mul_a = {1'b0, v_mag};
        mul_b = {1'b0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {{MulW{1'b0}}, mul_a} * {{MulW{1'b0}}, mul_b};

  // Square root step: bring down two bits, try root*4+1.
  logic [SremW-1:0] sq_rem, sq_trial;
  logic             sq_ge;
  assign sq_rem   = {srem_q[SremW-3:0], s_q[SumW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  // Divider: the first quotient bits above bit 30 only flag saturation.
  logic [DremW-1:0] div_init, div_sh, div_den;
  logic             div_ge;
  assign div_den  = {1'b0, d3_q};
  assign div_init = {{(DremW-ProdW+1){1'b0}}, prod_q[2*DataW-1:0], 1'b0};
  assign div_sh   = {drem_q[DremW-2:0], 1'b0};
  assign div_ge   = div_sh >= div_den;

  // Velocity change and saturating sum.
  logic [DataW-1:0] acc_mag;
  logic [DataW:0]   acc_val, vel_sum;
  logic             acc_neg;
  logic [DataW-1:0] vel_new;
  assign acc_mag = ovf_q ? SMax : {1'b0, quot_q};
  assign acc_neg = neg_q[cmd_i.axis] ^ cmd_i.body;
  assign acc_val = acc_neg ? -{1'b0, acc_mag} : {1'b0, acc_mag};
  assign vel_sum = {v_sel[DataW-1], v_sel} + acc_val;

  always_comb begin
    if (vel_sum[DataW] != vel_sum[DataW-1]) begin
      vel_new = vel_sum[DataW] ? SMin : SMax;
    end else begin
      vel_new = vel_sum[DataW-1:0];
    end
  end

  // Position change v*dt truncated toward zero, saturating sum.
  localparam int unsigned PsumW = DataW + FracW + 2;
  logic [PsumW-1:0] pd_mag, pd_val, pos_sum;
  logic [DataW-1:0] pos_new;
  assign pd_mag  = {2'b00, prod_q[2*DataW-1:FracW]};
  assign pd_val  = v_sel[DataW-1] ? -pd_mag : pd_mag;
  assign pos_sum = {{(PsumW-DataW){p_sel[DataW-1]}}, p_sel} + pd_val;

  always_comb begin
    if ((&pos_sum[PsumW-1:DataW-1]) || !(|pos_sum[PsumW-1:DataW-1])) begin
      pos_new = pos_sum[DataW-1:0];
    end else begin
      pos_new = pos_sum[PsumW-1] ? SMin : SMax;
    end
  end

  // Configuration and body state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass1_q <= MassRst;
      mass2_q <= MassRst;
      grav_q  <= GravRst;
      dt_q    <= DtRst;
      for (int i = 0; i < AxisN; i++) begin
        pos1_q[i] <= '0;
        pos2_q[i] <= '0;
        vel1_q[i] <= '0;
        vel2_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MASS_ONE: mass1_q <= cfg_data_i;
          CFG_MASS_TWO: mass2_q <= cfg_data_i;
          CFG_GRAV:     grav_q  <= cfg_data_i;
          CFG_DT:       dt_q    <= cfg_data_i;
          default:      mass1_q <= mass1_q;
        endcase
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (body_sel_i) begin
            pos2_q[0] <= load_pos_x_i;
            pos2_q[1] <= load_pos_y_i;
            pos2_q[2] <= load_pos_z_i;
            vel2_q[0] <= load_vel_x_i;
            vel2_q[1] <= load_vel_y_i;
            vel2_q[2] <= load_vel_z_i;
          end else begin
            pos1_q[0] <= load_pos_x_i;
            pos1_q[1] <= load_pos_y_i;
            pos1_q[2] <= load_pos_z_i;
            vel1_q[0] <= load_vel_x_i;
            vel1_q[1] <= load_vel_y_i;
            vel1_q[2] <= load_vel_z_i;
          end
        end
        OP_VEL: begin
          if (cmd_i.body) begin
            vel2_q[cmd_i.axis] <= vel_new;
          end else begin
            vel1_q[cmd_i.axis] <= vel_new;
          end
        end
        OP_POS: begin
          if (cmd_i.body) begin
            pos2_q[cmd_i.axis] <= pos_new;
          end else begin
            pos1_q[cmd_i.axis] <= pos_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the step.
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        s_q    <= '0;
        srem_q <= '0;
        root_q <= '0;
      end
      OP_DIFF: begin
        ad_q[cmd_i.axis]  <= ad_now;
        neg_q[cmd_i.axis] <= neg_now;
      end
      OP_SQ_ACC: begin
        s_q <= s_q + {{(SumW-ProdW){1'b0}}, prod_q};
      end
      OP_CHECK: begin
        coin_q <= (s_q == '0);
      end
      OP_SQRT_STEP: begin
        s_q <= {s_q[SumW-3:0], 2'b00};
        if (sq_ge) begin
          srem_q <= sq_rem - sq_trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          srem_q <= sq_rem;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      OP_DD: begin
        dd_q <= prod_q;
      end
      OP_D3LO: begin
        d3_q <= {{DistW{1'b0}}, prod_q};
      end
      OP_D3HI: begin
        d3_q <= d3_q + {prod_q, {DistW{1'b0}}};
      end
      OP_GM: begin
        gm_q <= sat_shift(prod_q);
      end
      OP_K: begin
        k_q[cmd_i.body] <= sat_shift(prod_q);
      end
      OP_DIV_INIT: begin
        drem_q <= div_init;
        ovf_q  <= div_init >= div_den;
        quot_q <= '0;
      end
      OP_DIV_STEP: begin
        if (div_ge) begin
          drem_q <= div_sh - div_den;
          quot_q <= {quot_q[QuotW-2:0], 1'b1};
        end else begin
          drem_q <= div_sh;
          quot_q <= {quot_q[QuotW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.s_zero = (s_q == '0);

  // Result fields straight from the body state.
  assign first_x_o    = pos1_q[0];
  assign first_y_o    = pos1_q[1];
  assign first_z_o    = pos1_q[2];
  assign second_x_o   = pos2_q[0];
  assign second_y_o   = pos2_q[1];
  assign second_z_o   = pos2_q[2];
  assign coincident_o = coin_q;

endmodule

`default_nettype wire

>>> rtl/two_body_gravity_step_top.sv
// Load transaction: gives no result; the next is accepted at once.
// Step transaction: the result follows the square root and six divisions on one
// divider; when the bodies coincide, both are skipped.
// One transaction is in flight at a time; a result waits until it is taken.
// Reset: bodies at rest at the origin, masses and G 1.0, time step 655/65536.
// ----------------------------------------------------------------------------
// Two-body gravity step top level
// Euler-Cromer integration of two bodies in Q16.16, controller plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module two_body_gravity_step_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tbgs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [tbgs_pkg::DataW-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              action_i,
  input  wire logic                              body_sel_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_pos_x_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_pos_y_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_pos_z_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_vel_x_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_vel_y_i,
  input  wire logic signed [tbgs_pkg::DataW-1:0] load_vel_z_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [tbgs_pkg::DataW-1:0]      first_x_o,
  output logic signed [tbgs_pkg::DataW-1:0]      first_y_o,
  output logic signed [tbgs_pkg::DataW-1:0]      first_z_o,
  output logic signed [tbgs_pkg::DataW-1:0]      second_x_o,
  output logic signed [tbgs_pkg::DataW-1:0]      second_y_o,
  output logic signed [tbgs_pkg::DataW-1:0]      second_z_o,
  output logic                                   coincident_o
);
  import tbgs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  tbgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  tbgs_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .body_sel_i   (body_sel_i),
    .load_pos_x_i (load_pos_x_i),
    .load_pos_y_i (load_pos_y_i),
    .load_pos_z_i (load_pos_z_i),
    .load_vel_x_i (load_vel_x_i),
    .load_vel_y_i (load_vel_y_i),
    .load_vel_z_i (load_vel_z_i),
    .first_x_o    (first_x_o),
    .first_y_o    (first_y_o),
    .first_z_o    (first_z_o),
    .second_x_o   (second_x_o),
    .second_y_o   (second_y_o),
    .second_z_o   (second_z_o),
    .coincident_o (coincident_o)
  );

endmodule

`default_nettype wire

>>> rtl/tbgs_checker.sv
// ----------------------------------------------------------------------------
// Two-body gravity step checker
// Port-level assertions on transaction ordering, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tbgs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic action_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i
);
  import tbgs_pkg::*;

  // Accepted transactions by kind.
  logic step_acc, load_acc, out_acc;
  assign step_acc = in_valid_i && in_ready_o && (action_i == ACT_STEP);
  assign load_acc = in_valid_i && in_ready_o && (action_i == ACT_LOAD);
  assign out_acc  = out_valid_o && out_ready_i;

  // A result on offer means no new transaction is taken.
  `ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)

  // A step keeps the block busy on the following cycle.
  `ASSERT_NXT(a_step_busy, clk_i, rst_ni, step_acc, !in_ready_o && !out_valid_o)

  // A load completes at once and gives no result.
  `ASSERT_NXT(a_load_done, clk_i, rst_ni, load_acc, in_ready_o && !out_valid_o)

  // A taken result returns the block to accepting input.
  `ASSERT_NXT(a_out_done, clk_i, rst_ni, out_acc, in_ready_o && !out_valid_o)

  // A stalled result stays offered.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind two_body_gravity_step_top tbgs_checker u_tbgs_checker (.*);

`default_nettype wire
